FILE: src/csg_pkg.sv
// Shared types and fixed field widths for the Catalan sequence generator.
// Depends on nothing; imported by catalan_sequence_generator_core.
package csg_pkg;

    localparam int IndexWidth = 6;
    localparam int ValueWidth = 64;
    localparam int HalfWidth  = 32;
    localparam int InDataWidth  = 8;
    localparam int OutDataWidth = 72;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_EMIT
    } t_state;

endpackage

FILE: src/catalan_sequence_generator_core.sv
// Catalan sequence generator: table memory, product pipeline and sequencer.
// Depends on csg_pkg for the state type and field widths.
//
// Channel  Dir  Handshake                   Payload
// s        in   i_s_tvalid / o_s_tready     i_s_tdata: last_index
// m        out  o_m_tvalid / i_m_tready     o_m_tdata: index, value; o_m_tlast: last
//
// An input transfer with last index N yields N+1 results. C(n) takes n product
// terms, one issued per cycle to two read ports of the table memory, followed
// by a drain of the split 64-bit multiply pipeline and an emit step. Reset
// (i_rst_n low at a clock edge) returns the sequencer to idle and drops the
// output valid. A stalled output holds the sequencer in its emit step.
module catalan_sequence_generator_core
    import csg_pkg::*;
#(
    parameter int MAX_INDEX = 63
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [InDataWidth-1:0]  i_s_tdata,   // [5:0] last_index, [7:6] zero
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [OutDataWidth-1:0] o_m_tdata,   // [5:0] index, [69:6] value, [71:70] zero
    output logic                    o_m_tlast
);

    localparam int Depth = MAX_INDEX + 1;
    localparam int AW    = (Depth > 2) ? $clog2(Depth) : 1;
    localparam int XW    = 9;

    t_state r_state, n_state;

    logic [AW-1:0]         r_last;
    logic [AW-1:0]         r_n;
    logic [AW-1:0]         r_i;
    logic [ValueWidth-1:0] r_sum;

    logic [ValueWidth-1:0] value_table [Depth];
    logic [ValueWidth-1:0] r_rd_a, r_rd_b;

    logic                  r_v0, r_v1, r_v2, r_v3;
    logic [ValueWidth-1:0] r_p0, r_s1a, r_s1b, r_p1, r_prod;
    logic [HalfWidth-1:0]  r_s2ah, r_s2bl;
    logic [HalfWidth-1:0]  w_m1, w_m2;

    logic                  r_out_valid;
    logic [IndexWidth-1:0] r_out_index;
    logic [ValueWidth-1:0] r_out_value;
    logic                  r_out_last;

    logic                  w_accept, w_issue, w_emit, w_slot_free, w_pipe_empty;
    logic                  w_term_last, w_n_last, w_sat;
    logic [AW-1:0]         w_addr_b;
    logic [XW-1:0]         w_n_ext;
    logic [IndexWidth-1:0] w_in_last;

    assign w_in_last    = i_s_tdata[IndexWidth-1:0];
    assign w_sat        = {3'b000, w_in_last} > XW'(MAX_INDEX);
    assign w_slot_free  = !r_out_valid || i_m_tready;
    assign w_pipe_empty = !(r_v0 || r_v1 || r_v2 || r_v3);
    assign w_term_last  = (r_i == r_n - AW'(1));
    assign w_n_last     = (r_n == r_last);
    assign w_addr_b     = r_n - AW'(1) - r_i;
    assign w_n_ext      = XW'(r_n);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_EMIT;
            end
            S_ISSUE: begin
                if (w_term_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (w_pipe_empty) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_slot_free) n_state = w_n_last ? S_IDLE : S_ISSUE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_s_tready = 1'b0;
        w_issue    = 1'b0;
        w_emit     = 1'b0;
        case (r_state)
            S_IDLE:  o_s_tready = 1'b1;
            S_ISSUE: w_issue    = 1'b1;
            S_DRAIN: ;
            S_EMIT:  w_emit     = w_slot_free;
            default: ;
        endcase
    end

    assign w_accept = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_n         <= '0;
            r_i         <= '0;
            r_sum       <= '0;
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v0    <= w_issue;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            r_v3    <= r_v2;

            if (w_accept) begin
                r_last <= w_sat ? AW'(MAX_INDEX) : AW'(w_in_last);
                r_n    <= '0;
                r_sum  <= ValueWidth'(1);
            end else if (w_emit) begin
                r_n   <= r_n + AW'(1);
                r_i   <= '0;
                r_sum <= '0;
            end else begin
                if (w_issue) r_i <= r_i + AW'(1);
                if (r_v3) r_sum <= r_sum + r_prod;
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Table memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (w_emit) value_table[r_n] <= r_sum;
        r_rd_a <= value_table[r_i];
        r_rd_b <= value_table[w_addr_b];
    end

    // Low 64 bits of a 64x64 product, one 32x32 multiplier per stage.
    assign w_m1 = r_s1a[HalfWidth-1:0] * r_s1b[ValueWidth-1:HalfWidth];
    assign w_m2 = r_s2ah * r_s2bl;

    always_ff @(posedge i_clk) begin
        r_p0   <= ValueWidth'(r_rd_a[HalfWidth-1:0]) * ValueWidth'(r_rd_b[HalfWidth-1:0]);
        r_s1a  <= r_rd_a;
        r_s1b  <= r_rd_b;
        r_p1   <= r_p0 + {w_m1, {HalfWidth{1'b0}}};
        r_s2ah <= r_s1a[ValueWidth-1:HalfWidth];
        r_s2bl <= r_s1b[HalfWidth-1:0];
        r_prod <= r_p1 + {w_m2, {HalfWidth{1'b0}}};
    end

    // Output register; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_index <= w_n_ext[IndexWidth-1:0];
            r_out_value <= r_sum;
            r_out_last  <= w_n_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_value, r_out_index};
    assign o_m_tlast  = r_out_last;

endmodule

FILE: sim/tb.sv
// Self-checking testbench for catalan_sequence_generator_core: drives last-index
// requests, predicts the wrapped Catalan sequence for each and checks every result.
// Depends on csg_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb
    import csg_pkg::*;
();

    localparam int MaxIndex    = 63;
    localparam int QuietLimit  = 20000;
    localparam int DrainCycles = 100;
    localparam int RandPerPhase = 50;

    typedef struct {
        logic [IndexWidth-1:0] index;
        logic [ValueWidth-1:0] value;
        logic                  is_last;
    } t_catalan_term;

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic [InDataWidth-1:0]  s_tdata = '0;
    logic                    o_s_tready;
    logic                    o_m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OutDataWidth-1:0] o_m_tdata;   // [5:0] index, [69:6] value, [71:70] zero
    logic                    o_m_tlast;

    logic [IndexWidth-1:0] request_q[$];
    t_catalan_term         catalan_due[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int requests_sent  = 0;
    int terms_checked  = 0;
    int longest_run    = 0;
    int quiet_cycles   = 0;

    catalan_sequence_generator_core #(
        .MAX_INDEX(MaxIndex)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Every request rebuilds the sequence from C(0); products and sums wrap at 64 bits.
    function automatic void queue_catalan_run(input logic [IndexWidth-1:0] last_index);
        logic [ValueWidth-1:0] cat_vals[0:MaxIndex];
        logic [ValueWidth-1:0] acc;
        t_catalan_term         term;
        int                    top;
        top = (int'(last_index) > MaxIndex) ? MaxIndex : int'(last_index);
        for (int n = 0; n <= top; n++) begin
            if (n == 0) begin
                acc = 64'd1;
            end else begin
                acc = '0;
                for (int i = 0; i < n; i++) begin
                    acc = acc + cat_vals[i] * cat_vals[n - 1 - i];
                end
            end
            cat_vals[n]  = acc;
            term.index   = IndexWidth'(n);
            term.value   = acc;
            term.is_last = (n == top);
            catalan_due.push_back(term);
        end
        if (top + 1 > longest_run) begin
            longest_run = top + 1;
        end
    endfunction

    // Driver: a new request goes out only once the previous transfer has completed.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                queue_catalan_run(s_tdata[IndexWidth-1:0]);
                requests_sent++;
            end
            if (!s_tvalid || o_s_tready) begin
                if (request_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, request_q.pop_front()};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Monitor: each output transfer is matched against the oldest predicted term.
    always @(posedge i_clk) begin
        t_catalan_term want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (catalan_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: index %0d value %h last %b",
                             o_m_tdata[5:0], o_m_tdata[69:6], o_m_tlast);
                end
            end else begin
                want = catalan_due.pop_front();
                terms_checked++;
                if (o_m_tdata[5:0] !== want.index || o_m_tdata[69:6] !== want.value ||
                    o_m_tlast !== want.is_last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected index %0d value %h last %b, got %0d %h %b",
                                 want.index, want.value, want.is_last,
                                 o_m_tdata[5:0], o_m_tdata[69:6], o_m_tlast);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QuietLimit) begin
                $display("timeout: no transfer for %0d cycles", QuietLimit);
                $display("CHECK FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic wait_all_done();
        do @(negedge i_clk);
        while (request_q.size() != 0 || s_tvalid || catalan_due.size() != 0);
    endtask

    initial begin
        logic [IndexWidth-1:0] pick;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: zero index, small indexes, the wrap point, the top, alternating bits,
        // and back-to-back repeats.
        request_q = {6'd0, 6'd1, 6'd2, 6'd63, 6'd0, 6'd36, 6'd37, 6'd42, 6'd21,
                     6'd5, 6'd5, 6'd63, 6'd62, 6'd1, 6'd0};
        wait_all_done();

        // Random phases: none, sender idle, receiver stall, both. Between phases the
        // sender holds off until every predicted term has arrived.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 48 : (phase == 3) ? 13 : 0;
            recv_stall_pct = (phase == 2) ? 48 : (phase == 3) ? 13 : 0;
            for (int k = 0; k < RandPerPhase; k++) begin
                // Mostly short runs keep the run time down; some span the full range.
                if ($urandom_range(9, 0) < 7) begin
                    pick = IndexWidth'($urandom_range(15, 0));
                end else begin
                    pick = IndexWidth'($urandom_range(63, 0));
                end
                request_q.push_back(pick);
            end
            wait_all_done();
        end

        repeat (DrainCycles) @(posedge i_clk);
        $display("covered %0d requests and %0d results, longest sequence %0d terms",
                 requests_sent, terms_checked, longest_run);
        $display("mismatches: %0d, terms still outstanding: %0d",
                 mismatches, catalan_due.size());
        if (mismatches == 0 && catalan_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: catalan_sequence_generator_core.f
src/csg_pkg.sv
src/catalan_sequence_generator_core.sv
sim/tb.sv
